/* hw/rtl/mbb_pkg.sv */
`timescale 1ns / 1ps

package mbb_pkg;

	localparam int CFG_W      = 12;
	localparam int RD_ADDR_W  = 16;
	// Widest store is 512 bytes a row by 4096 rows.
	localparam int CMD_ADDR_W = 21;

	localparam logic [7:0] WHITE = 8'hFF;

	typedef enum logic [1:0] {
		OP_BLIT  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_DEST_X       = 2'd0,
		REG_DEST_Y       = 2'd1,
		REG_IMAGE_WIDTH  = 2'd2,
		REG_IMAGE_HEIGHT = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_BLIT,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WR_A,
		ST_WR_B,
		ST_READ,
		ST_CLEAR
	} back_state_t;

	// One classified item on its way to the store. For a clear the fill byte is in data_a.
	typedef struct packed {
		cmd_kind_t             kind;
		logic [CMD_ADDR_W-1:0] addr;
		logic [7:0]            mask_a;
		logic [7:0]            mask_b;
		logic [7:0]            data_a;
		logic [7:0]            data_b;
		logic                  done;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       blit_done;
	} rslt_t;

endpackage

/* hw/rtl/mbb_front.sv */
`timescale 1ns / 1ps

module mbb_front import mbb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 800
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [1:0]           opcode,
	input  logic [7:0]           data_byte,
	input  logic                 image_start,
	input  logic [RD_ADDR_W-1:0] read_address,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output cmd_t                 q_cmd,
	output logic                 stall
);

	localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
	localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;

	logic [CFG_W-1:0] dest_x_q, dest_y_q, image_width_q, image_height_q;
	logic [11:0]      row_q, row_d, cur_row;
	logic [8:0]       col_q, col_d, cur_col;

	opcode_t     op;
	logic [9:0]  row_bytes;
	logic        active, row_end, last;
	logic [12:0] py, px_base;
	logic [11:0] col0;
	logic [7:0]  mask8;
	cmd_kind_t   kind_d;

	logic                 s1_valid_q;
	cmd_kind_t            kind_s1;
	logic [7:0]           data_s1, mask_s1;
	logic                 done_s1;
	logic [11:0]          py_s1;
	logic [9:0]           pxb_s1;
	logic [2:0]           sh_s1;
	logic [RD_ADDR_W-1:0] raddr_s1;

	logic [CMD_ADDR_W-1:0] row_base;
	logic [15:0]           win_m, win_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q       <= '0;
			dest_y_q       <= '0;
			image_width_q  <= '0;
			image_height_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_DEST_X:       dest_x_q       <= cfg_data;
				REG_DEST_Y:       dest_y_q       <= cfg_data;
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		op        = opcode_t'(opcode);
		row_bytes = 10'((13'(image_width_q) + 13'd7) >> 3);
		cur_row   = image_start ? '0 : row_q;
		cur_col   = image_start ? '0 : col_q;
		active    = (row_bytes != '0) && (image_height_q != '0) && (cur_row < image_height_q);
		row_end   = (10'(cur_col) + 10'd1) >= row_bytes;
		last      = active && row_end && ((13'(cur_row) + 13'd1) == 13'(image_height_q));
		py        = 13'(dest_y_q) + 13'(cur_row);
		col0      = {cur_col, 3'b000};
		px_base   = 13'(dest_x_q) + 13'(col0);
		// Valid pixels of a source byte always form a run that starts at its MSB.
		for (int b = 0; b < 8; b++) begin
			mask8[3'(7 - b)] = (py < 13'(SCREEN_HEIGHT))
				&& ((13'(col0) + 13'(b)) < 13'(image_width_q))
				&& ((px_base + 13'(b)) < 13'(SCREEN_WIDTH));
		end

		row_d = row_q;
		col_d = col_q;
		if (in_fire && op == OP_BLIT) begin
			row_d = cur_row;
			col_d = cur_col;
			if (active) begin
				if (row_end) begin
					col_d = '0;
					row_d = cur_row + 12'd1;
				end else begin
					col_d = cur_col + 9'd1;
				end
			end
		end

		unique case (op)
			OP_BLIT:  kind_d = (active && mask8 != '0) ? CMD_BLIT : CMD_NOP;
			OP_CLEAR: kind_d = CMD_CLEAR;
			OP_READ:  kind_d = ({6'b0, read_address} < 22'(STORE_BYTES)) ? CMD_READ : CMD_NOP;
			OP_NONE:  kind_d = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			row_q <= row_d;
			col_q <= col_d;
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (q_push) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= kind_d;
			data_s1  <= data_byte;
			mask_s1  <= mask8;
			done_s1  <= (op == OP_BLIT) && last;
			py_s1    <= py[11:0];
			pxb_s1   <= px_base[12:3];
			sh_s1    <= px_base[2:0];
			raddr_s1 <= read_address;
		end
	end

	assign q_push = s1_valid_q && !q_full;
	assign stall  = s1_valid_q && q_full;

	always_comb begin
		row_base     = CMD_ADDR_W'(py_s1) * CMD_ADDR_W'(ROW_BYTES);
		win_m        = {mask_s1, 8'h00} >> sh_s1;
		win_d        = {data_s1, 8'h00} >> sh_s1;
		q_cmd.kind   = kind_s1;
		q_cmd.addr   = (kind_s1 == CMD_READ) ? CMD_ADDR_W'(raddr_s1)
			: row_base + CMD_ADDR_W'(pxb_s1);
		q_cmd.mask_a = win_m[15:8];
		q_cmd.mask_b = win_m[7:0];
		q_cmd.data_a = (kind_s1 == CMD_CLEAR) ? data_s1 : win_d[15:8];
		q_cmd.data_b = win_d[7:0];
		q_cmd.done   = done_s1;
	end

	a_blit_has_lead_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && kind_s1 == CMD_BLIT |-> mask_s1[7])
		else $error("blit command without a leading valid pixel");

	a_read_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_cmd.kind == CMD_READ |-> {1'b0, q_cmd.addr} < 22'(STORE_BYTES))
		else $error("read command outside the frame store");

endmodule

/* hw/rtl/mbb_cmd_q.sv */
`timescale 1ns / 1ps

module mbb_cmd_q import mbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign head    = ent_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

endmodule

/* hw/rtl/mbb_back.sv */
`timescale 1ns / 1ps

module mbb_back import mbb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 800
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  cmd_t  cmd,
	output logic  cmd_pop,
	input  logic  rslt_pop,
	output logic  rslt_valid,
	output rslt_t rslt,
	output logic  init_busy
);

	localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
	localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	logic [7:0] frame_q [STORE_BYTES];
	logic [7:0] rd_data_q;

	back_state_t       state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	cmd_t              cur_q;
	logic              out_valid_q;
	rslt_t             out_q;

	logic              wr_en, rd_en, fin, load_cur, can_start, last;
	logic [ADDR_W-1:0] wr_addr, rd_addr, cur_a, cur_b;
	logic [7:0]        wr_data;
	rslt_t             fin_rslt;

	assign last      = (cnt_q == ADDR_W'(STORE_BYTES - 1));
	assign can_start = !out_valid_q || rslt_pop;
	assign cur_a     = cur_q.addr[ADDR_W-1:0];
	assign cur_b     = cur_a + ADDR_W'(1);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd_pop  = 1'b0;
		load_cur = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = cnt_q;
		wr_data  = WHITE;
		rd_en    = 1'b0;
		rd_addr  = cmd.addr[ADDR_W-1:0];
		fin      = 1'b0;
		fin_rslt = '0;
		unique case (state_q)
			ST_INIT: begin
				wr_en = 1'b1;
				if (last) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + ADDR_W'(1);
				end
			end
			ST_IDLE: begin
				if (cmd_valid && can_start) begin
					cmd_pop  = 1'b1;
					load_cur = 1'b1;
					unique case (cmd.kind)
						CMD_NOP: begin
							fin                = 1'b1;
							fin_rslt.blit_done = cmd.done;
						end
						CMD_BLIT: begin
							rd_en   = 1'b1;
							state_d = ST_WR_A;
						end
						CMD_READ: begin
							rd_en   = 1'b1;
							state_d = ST_READ;
						end
						CMD_CLEAR: begin
							cnt_d   = '0;
							state_d = ST_CLEAR;
						end
					endcase
				end
			end
			ST_WR_A: begin
				wr_en   = 1'b1;
				wr_addr = cur_a;
				wr_data = (rd_data_q & ~cur_q.mask_a) | (cur_q.data_a & cur_q.mask_a);
				// A byte that straddles two store bytes needs a second read-modify-write.
				if (cur_q.mask_b != '0) begin
					rd_en   = 1'b1;
					rd_addr = cur_b;
					state_d = ST_WR_B;
				end else begin
					fin                = 1'b1;
					fin_rslt.blit_done = cur_q.done;
					state_d            = ST_IDLE;
				end
			end
			ST_WR_B: begin
				wr_en              = 1'b1;
				wr_addr            = cur_b;
				wr_data            = (rd_data_q & ~cur_q.mask_b) | (cur_q.data_b & cur_q.mask_b);
				fin                = 1'b1;
				fin_rslt.blit_done = cur_q.done;
				state_d            = ST_IDLE;
			end
			ST_READ: begin
				fin                = 1'b1;
				fin_rslt.read_data = rd_data_q;
				state_d            = ST_IDLE;
			end
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = cur_q.data_a;
				if (last) begin
					cnt_d   = '0;
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + ADDR_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rslt_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_q <= cmd;
		end
		if (fin) begin
			out_q <= fin_rslt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= frame_q[rd_addr];
		end
	end

	assign rslt_valid = out_valid_q;
	assign rslt       = out_q;
	assign init_busy  = (state_q == ST_INIT);

	a_second_byte_needed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR_B |-> cur_q.mask_b != 8'h00)
		else $error("second read-modify-write without pixels for it");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!out_valid_q || rslt_pop))
		else $error("result written over one still waiting");

	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_INIT |=> state_q != ST_INIT)
		else $error("clearing pass restarted");

	a_sweep_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR && !last |=> cnt_q == $past(cnt_q) + ADDR_W'(1))
		else $error("clear sweep skipped an address");

endmodule

/* hw/rtl/mono_bitmap_blitter.sv */
`timescale 1ns / 1ps

// Channel   Handshake         Payload
// input     push / full       opcode, data_byte, image_start, read_address
// result    empty / pop       read_data, blit_done
// config    cfg_write         cfg_index, cfg_data
//
// After reset the store is swept to white, one byte a cycle,
// with full held high. The front takes one item a cycle while the command queue has room.
// With one read and one write a cycle, the store engine ends an unused opcode, a read outside
// the store or a blit byte with no visible pixel in ST_IDLE; a blit byte is written in ST_WR_A,
// and in ST_WR_B when it spans two store bytes; a read ends in ST_READ, a clear in ST_CLEAR.
// A waiting result stalls only the store engine; the queue keeps taking beats while it has room.

module mono_bitmap_blitter import mbb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 800
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           opcode,
	input  logic [7:0]           data_byte,
	input  logic                 image_start,
	input  logic [RD_ADDR_W-1:0] read_address,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           read_data,
	output logic                 blit_done,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic  in_fire, stall, init_busy;
	logic  q_push, q_full, q_valid, q_pop;
	cmd_t  q_cmd, q_head;
	logic  rslt_valid, rslt_pop;
	rslt_t rslt;

	assign full     = init_busy || stall;
	assign in_fire  = push && !full;
	assign empty    = !rslt_valid;
	assign rslt_pop = pop && rslt_valid;

	assign read_data = rslt.read_data;
	assign blit_done = rslt.blit_done;

	mbb_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.image_start (image_start),
		.read_address(read_address),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd),
		.stall       (stall)
	);

	mbb_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (q_head)
	);

	mbb_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.rslt_pop  (rslt_pop),
		.rslt_valid(rslt_valid),
		.rslt      (rslt),
		.init_busy (init_busy)
	);

endmodule
